// File: src/ptc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_pkg
// Types and constants for the palette cross-fade block: beat structs,
// command codes and fixed arithmetic limits.
// ----------------------------------------------------------------------------
package ptc_pkg;

    typedef logic [7:0] t_byte;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_FRAME = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam int BYTES_PER_ENTRY = 3;
    localparam int DIV_STEPS       = 8;
    localparam int COLOR_MAX       = 255;
    localparam logic signed [8:0] NO_LEVEL = -9'sd128;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [9:0]  byte_index;
        logic [7:0]  byte_value;
        logic [7:0]  entry_index;
        logic [15:0] duration_ms;
        logic [31:0] now_ms;
    } t_ptc_in;

    typedef struct packed {
        logic               palette_changed;
        logic               fading;
        logic signed [31:0] time_left_ms;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } t_ptc_out;

endpackage

// File: src/ptc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_ram
// Byte-wide single-port-write, single-port-read memory with registered read.
// ----------------------------------------------------------------------------
module ptc_ram
    import ptc_pkg::*;
#(
    parameter int DEPTH = 768,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_byte         i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_byte         o_rdata
);

    t_byte r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: src/palette_timed_crossfade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_timed_crossfade
// Timed linear cross-fade between an origin and a target RGB palette.
// ----------------------------------------------------------------------------
// Every accepted beat gives exactly one result beat, shown on o_beat for a
// single cycle with o_valid high; the receiver cannot hold it off. After
// reset the block sweeps all three palette memories to zero, one byte a
// cycle, and holds busy high until that sweep ends. A target write, a frame
// update with no fade running and an out-of-range read are answered in the
// cycle after accept. An entry read sweeps its three bytes of the current
// palette; a fade start sweeps the palette to copy current into origin; a
// frame update that ends the fade copies target into current; a frame update
// that does not end it first divides to find the level, answers without a
// sweep if the level is unchanged, and else reblends the whole palette. The
// shared datapath is one 32-bit subtract/compare for the 8-step level division
// and one blend unit fed by the memory read ports, so the sweeps run one palette byte per cycle.
// ----------------------------------------------------------------------------
module palette_timed_crossfade
    import ptc_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_ptc_in  i_beat,
    output logic     busy,
    output logic     o_valid,
    output t_ptc_out o_beat
);

    localparam int PAL_BYTES = BYTES_PER_ENTRY * PALETTE_ENTRIES;
    localparam int AW        = $clog2(PAL_BYTES);
    localparam int CW        = $clog2(DIV_STEPS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(PAL_BYTES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_DECIDE,
        S_DIV,
        S_LEVEL,
        S_SWEEP,
        S_DRAIN
    } t_state;

    typedef enum logic [1:0] {
        OP_COPY_ORG,
        OP_COPY_CUR,
        OP_BLEND,
        OP_READ
    } t_op;

    t_state          r_state;
    t_op             r_op;
    logic [AW-1:0]   r_addr;
    logic [AW-1:0]   r_last;
    logic            r_pv;
    logic [AW-1:0]   r_pa;
    logic [1:0]      r_sel;
    t_byte           r_red;
    t_byte           r_green;
    logic [31:0]     r_now;
    logic [31:0]     r_start_t;
    logic [31:0]     r_end_t;
    logic            r_fade_on;
    logic signed [8:0] r_last_level;
    logic            r_changed;
    logic [31:0]     r_len;
    logic [31:0]     r_pos;
    logic [31:0]     r_rem;
    logic [7:0]      r_quo;
    logic [CW-1:0]   r_cnt;

    logic            n_valid;
    t_ptc_out        n_beat;

    t_byte           tgt_q;
    t_byte           org_q;
    t_byte           cur_q;

    logic            accept;
    logic            clearing;
    logic            byte_ok;
    logic            entry_ok;
    logic [9:0]      rd_base;
    logic [9:0]      rd_end;
    logic [32:0]     rem2;
    logic [32:0]     diff;
    logic [7:0]      lvl_scaled;
    logic            lvl_same;
    logic [15:0]     prod_t;
    logic [15:0]     prod_o;
    logic [16:0]     blend_sum;
    logic [8:0]      blend_sh;
    t_byte           blend;
    logic [31:0]     t_now;

    logic            tgt_we;
    logic [AW-1:0]   tgt_waddr;
    t_byte           tgt_wdata;
    logic            org_we;
    logic [AW-1:0]   org_waddr;
    t_byte           org_wdata;
    logic            cur_we;
    logic [AW-1:0]   cur_waddr;
    t_byte           cur_wdata;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign clearing = (r_state == S_CLEAR);
    assign byte_ok  = (i_beat.byte_index < 10'(PAL_BYTES));
    assign entry_ok = ({1'b0, i_beat.entry_index} < 9'(PALETTE_ENTRIES));
    assign rd_base  = {2'b00, i_beat.entry_index} + {1'b0, i_beat.entry_index, 1'b0};
    assign rd_end   = rd_base + 10'(BYTES_PER_ENTRY - 1);

    // restoring division step
    assign rem2 = {r_rem, 1'b0};
    assign diff = rem2 - {1'b0, r_len};

    assign lvl_scaled = (r_quo == 8'd0) ? 8'd0 : r_quo - 8'd1;
    assign lvl_same   = ($signed({1'b0, lvl_scaled}) == r_last_level);

    // blend unit
    assign prod_t    = tgt_q * r_quo;
    assign prod_o    = org_q * (8'(COLOR_MAX) - r_quo);
    assign blend_sum = {1'b0, prod_t} + {1'b0, prod_o};
    assign blend_sh  = blend_sum[16:8];
    assign blend     = (blend_sh > 9'(COLOR_MAX)) ? 8'(COLOR_MAX) : blend_sh[7:0];

    assign tgt_we    = clearing || (accept && i_beat.cmd == CMD_WRITE && byte_ok);
    assign tgt_waddr = clearing ? r_addr : i_beat.byte_index[AW-1:0];
    assign tgt_wdata = clearing ? 8'd0 : i_beat.byte_value;

    assign org_we    = clearing || (r_pv && r_op == OP_COPY_ORG);
    assign org_waddr = clearing ? r_addr : r_pa;
    assign org_wdata = clearing ? 8'd0 : cur_q;

    assign cur_we    = clearing || (r_pv && (r_op == OP_COPY_CUR || r_op == OP_BLEND));
    assign cur_waddr = clearing ? r_addr : r_pa;
    assign cur_wdata = clearing ? 8'd0 : ((r_op == OP_BLEND) ? blend : tgt_q);

    ptc_ram #(.DEPTH(PAL_BYTES), .AW(AW)) u_tgt_ram (
        .i_clk   (i_clk),
        .i_we    (tgt_we),
        .i_waddr (tgt_waddr),
        .i_wdata (tgt_wdata),
        .i_raddr (r_addr),
        .o_rdata (tgt_q)
    );

    ptc_ram #(.DEPTH(PAL_BYTES), .AW(AW)) u_org_ram (
        .i_clk   (i_clk),
        .i_we    (org_we),
        .i_waddr (org_waddr),
        .i_wdata (org_wdata),
        .i_raddr (r_addr),
        .o_rdata (org_q)
    );

    ptc_ram #(.DEPTH(PAL_BYTES), .AW(AW)) u_cur_ram (
        .i_clk   (i_clk),
        .i_we    (cur_we),
        .i_waddr (cur_waddr),
        .i_wdata (cur_wdata),
        .i_raddr (r_addr),
        .o_rdata (cur_q)
    );

    // result beat
    assign t_now = (r_state == S_IDLE) ? i_beat.now_ms : r_now;

    always_comb begin
        n_valid                = 1'b0;
        n_beat.palette_changed = 1'b0;
        n_beat.fading          = r_fade_on;
        n_beat.time_left_ms    = $signed(r_end_t - t_now);
        n_beat.red             = 8'd0;
        n_beat.green           = 8'd0;
        n_beat.blue            = 8'd0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_beat.cmd)
                        CMD_WRITE: n_valid = 1'b1;
                        CMD_FRAME: n_valid = !r_fade_on;
                        CMD_READ:  n_valid = !entry_ok;
                        default:   n_valid = 1'b0;
                    endcase
                end
            end
            S_LEVEL: begin
                n_valid = lvl_same;
            end
            S_DRAIN: begin
                n_valid                = 1'b1;
                n_beat.palette_changed = r_changed;
                if (r_op == OP_READ) begin
                    n_beat.red   = r_red;
                    n_beat.green = r_green;
                    n_beat.blue  = cur_q;
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_addr       <= '0;
            r_pv         <= 1'b0;
            r_fade_on    <= 1'b0;
            r_last_level <= NO_LEVEL;
            r_start_t    <= '0;
            r_end_t      <= '0;
            o_valid      <= 1'b0;
        end else begin
            o_valid <= n_valid;
            r_pv    <= (r_state == S_SWEEP);
            r_pa    <= r_addr;
            if (r_pv && r_op == OP_READ) begin
                r_sel <= r_sel + 2'd1;
                if (r_sel == 2'd0) begin
                    r_red <= cur_q;
                end
                if (r_sel == 2'd1) begin
                    r_green <= cur_q;
                end
            end
            case (r_state)
                S_CLEAR: begin
                    if (r_addr == LAST_ADDR) begin
                        r_addr  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_now     <= i_beat.now_ms;
                        r_changed <= 1'b0;
                        r_sel     <= 2'd0;
                        case (i_beat.cmd)
                            CMD_START: begin
                                r_start_t <= i_beat.now_ms;
                                r_end_t   <= i_beat.now_ms + {16'd0, i_beat.duration_ms};
                                r_fade_on <= 1'b1;
                                r_op      <= OP_COPY_ORG;
                                r_addr    <= '0;
                                r_last    <= LAST_ADDR;
                                r_state   <= S_SWEEP;
                            end
                            CMD_FRAME: begin
                                if (r_fade_on) begin
                                    r_state <= S_EVAL;
                                end
                            end
                            CMD_READ: begin
                                if (entry_ok) begin
                                    r_op    <= OP_READ;
                                    r_addr  <= rd_base[AW-1:0];
                                    r_last  <= rd_end[AW-1:0];
                                    r_state <= S_SWEEP;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_EVAL: begin
                    r_len   <= r_end_t - r_start_t;
                    r_pos   <= r_now - r_start_t;
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (r_len == 32'd0 || $signed(r_pos) >= $signed(r_len)) begin
                        r_fade_on    <= 1'b0;
                        r_last_level <= NO_LEVEL;
                        r_changed    <= 1'b1;
                        r_op         <= OP_COPY_CUR;
                        r_addr       <= '0;
                        r_last       <= LAST_ADDR;
                        r_state      <= S_SWEEP;
                    end else begin
                        r_rem   <= r_pos[31] ? 32'd0 : r_pos;
                        r_quo   <= 8'd0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= diff[32] ? rem2[31:0] : diff[31:0];
                    r_quo <= {r_quo[6:0], !diff[32]};
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(DIV_STEPS - 1)) begin
                        r_state <= S_LEVEL;
                    end
                end
                S_LEVEL: begin
                    if (lvl_same) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_last_level <= $signed({1'b0, lvl_scaled});
                        r_changed    <= 1'b1;
                        r_op         <= OP_BLEND;
                        r_addr       <= '0;
                        r_last       <= LAST_ADDR;
                        r_state      <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    if (r_addr == r_last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                S_DRAIN: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_valid) begin
            o_beat <= n_beat;
        end
    end

endmodule

// File: src/ptc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_checker
// Port-level checks for the palette cross-fade block, bound to the top level.
// ----------------------------------------------------------------------------
module ptc_checker
    import ptc_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     start,
    input t_ptc_in  i_beat,
    input logic     busy,
    input logic     o_valid,
    input t_ptc_out o_beat
);

    logic [1:0]  r_cmd;
    logic [15:0] r_dur;

    // command of the beat whose result is pending
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_cmd <= i_beat.cmd;
            r_dur <= i_beat.duration_ms;
        end
    end

    a_clear_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("busy low right after reset");

    a_write_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_beat.cmd == CMD_WRITE) |=> o_valid)
        else $error("target write beat not answered next cycle");

    a_rgb_only_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_cmd != CMD_READ) |->
        (o_beat.red == 8'd0 && o_beat.green == 8'd0 && o_beat.blue == 8'd0))
        else $error("color on a non-read result");

    a_change_only_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_cmd != CMD_FRAME) |-> !o_beat.palette_changed)
        else $error("palette change flagged outside a frame update");

    a_start_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_cmd == CMD_START) |->
        (o_beat.fading && o_beat.time_left_ms == $signed({16'd0, r_dur})))
        else $error("fade start result wrong");

endmodule

bind palette_timed_crossfade ptc_checker u_ptc_checker (.*);
